@@ design/iexu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute unit package
// Shared types, opcodes and constants for the integer execute unit.
// ----------------------------------------------------------------------------
package iexu_pkg;

  localparam int unsigned RegCount = 32;
  localparam int unsigned RegIdxW  = $clog2(RegCount);
  localparam int unsigned QDepth   = 2;
  localparam int unsigned QPtrW    = $clog2(QDepth);

  localparam logic [31:0] HaltWord  = 32'hffff_ffff;
  localparam logic [31:0] StackInit = 32'h0010_0000;
  localparam logic [31:0] PcInit    = 32'h0000_4000;

  // Opcodes.
  localparam logic [3:0] OpAlu   = 4'd0;
  localparam logic [3:0] OpFpu   = 4'd1;
  localparam logic [3:0] OpLdi   = 4'd2;
  localparam logic [3:0] OpLdih  = 4'd3;
  localparam logic [3:0] OpStore = 4'd6;
  localparam logic [3:0] OpLoad  = 4'd8;
  localparam logic [3:0] OpJal   = 4'd11;
  localparam logic [3:0] OpJr    = 4'd12;
  localparam logic [3:0] OpBne   = 4'd13;
  localparam logic [3:0] OpBeq   = 4'd15;

  // ALU tags.
  localparam logic [4:0] TagAdd  = 5'd0;
  localparam logic [4:0] TagSub  = 5'd1;
  localparam logic [4:0] TagShl  = 5'd2;
  localparam logic [4:0] TagShr  = 5'd3;
  localparam logic [4:0] TagSar  = 5'd4;
  localparam logic [4:0] TagAnd  = 5'd5;
  localparam logic [4:0] TagOr   = 5'd6;
  localparam logic [4:0] TagXor  = 5'd7;
  localparam logic [4:0] TagCne  = 5'd24;
  localparam logic [4:0] TagCeq  = 5'd25;
  localparam logic [4:0] TagClt  = 5'd26;
  localparam logic [4:0] TagCle  = 5'd27;
  localparam logic [4:0] TagFne  = 5'd28;
  localparam logic [4:0] TagFeq  = 5'd29;
  localparam logic [4:0] TagFlt  = 5'd30;
  localparam logic [4:0] TagFle  = 5'd31;

  // Result status codes.
  localparam logic [1:0] StExec   = 2'd0;
  localparam logic [1:0] StHalt   = 2'd1;
  localparam logic [1:0] StBadTag = 2'd2;
  localparam logic [1:0] StUnsup  = 2'd3;

  // Classified request passed from the front end to the back end.
  typedef struct packed {
    logic [1:0]  status;
    logic        halt;
    logic [3:0]  opcode;
    logic [4:0]  tag;
    logic [4:0]  rx;
    logic [4:0]  ra;
    logic [4:0]  rb;
    logic [31:0] lit;
    logic [31:0] disp;
  } dec_t;

endpackage

@@ design/iexu_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute unit front end
// Classifies each instruction word and queues it for the back end.
// ----------------------------------------------------------------------------
module iexu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  output logic              stall,
  input  logic [31:0]       instruction,
  output logic              q_valid,
  input  logic              q_pop,
  output iexu_pkg::dec_t    q_data
);

  iexu_pkg::dec_t dec;
  iexu_pkg::dec_t mem [iexu_pkg::QDepth];
  logic [iexu_pkg::QPtrW-1:0] wr_ptr;
  logic [iexu_pkg::QPtrW-1:0] rd_ptr;
  logic [iexu_pkg::QPtrW:0]   count;
  logic push;

  // Field extraction and status classification.
  always_comb begin
    dec.opcode = instruction[31:28];
    dec.rx     = instruction[27:23];
    dec.ra     = instruction[22:18];
    dec.rb     = instruction[17:13];
    dec.tag    = instruction[4:0];
    dec.lit    = {{24{instruction[12]}}, instruction[12:5]};
    dec.disp   = {{16{instruction[15]}}, instruction[15:0]};
    dec.halt   = (instruction == iexu_pkg::HaltWord);
    if (dec.halt) begin
      dec.status = iexu_pkg::StHalt;
    end else if (dec.opcode == iexu_pkg::OpFpu || dec.opcode == iexu_pkg::OpStore ||
                 dec.opcode == iexu_pkg::OpLoad) begin
      dec.status = iexu_pkg::StUnsup;
    end else if (dec.opcode == iexu_pkg::OpAlu && dec.tag > iexu_pkg::TagXor &&
                 dec.tag < iexu_pkg::TagCne) begin
      dec.status = iexu_pkg::StBadTag;
    end else begin
      dec.status = iexu_pkg::StExec;
    end
  end

  assign stall   = (count == (iexu_pkg::QPtrW+1)'(iexu_pkg::QDepth));
  assign push    = valid && !stall;
  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= dec;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (iexu_pkg::QPtrW+1)'(push) - (iexu_pkg::QPtrW+1)'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (iexu_pkg::QPtrW+1)'(iexu_pkg::QDepth))
    else $error("queue count overflow");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !q_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not advance");

endmodule

@@ design/iexu_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute unit back end
// Executes queued requests against the register file and program counter.
// ----------------------------------------------------------------------------
module iexu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_pop,
  input  iexu_pkg::dec_t    q_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic              write_enable,
  output logic [4:0]        write_index,
  output logic [31:0]       write_value,
  output logic [31:0]       next_pc
);

  logic [31:0] regs [iexu_pkg::RegCount];
  logic [31:0] pc;
  logic [31:0] a, b, x, bl, alu_res, val, nxt, br_tgt;
  logic [4:0]  sh;
  logic        we, nan_a, nan_b, un;
  logic [31:0] ka, kb;
  logic        load;

  function automatic logic [31:0] fkey(input logic [31:0] v);
    logic [31:0] z;
    z = (v[30:0] == '0) ? 32'd0 : v;
    return z[31] ? ~z : (z | 32'h8000_0000);
  endfunction

  assign a  = regs[q_data.ra];
  assign b  = regs[q_data.rb];
  assign x  = regs[q_data.rx];
  assign bl = b + q_data.lit;
  assign sh = bl[4:0];
  assign nan_a = (a[30:23] == 8'hff) && (a[22:0] != '0);
  assign nan_b = (b[30:23] == 8'hff) && (b[22:0] != '0);
  assign un = nan_a || nan_b;
  assign ka = fkey(a);
  assign kb = fkey(b);
  assign br_tgt = pc + 32'd4 + {q_data.disp[29:0], 2'b00};

  // ALU operations.
  always_comb begin
    case (q_data.tag)
      iexu_pkg::TagAdd: alu_res = a + b + q_data.lit;
      iexu_pkg::TagSub: alu_res = a - b - q_data.lit;
      iexu_pkg::TagShl: alu_res = a << sh;
      iexu_pkg::TagShr: alu_res = a >> sh;
      iexu_pkg::TagSar: alu_res = 32'($signed(a) >>> sh);
      iexu_pkg::TagAnd: alu_res = a & b & q_data.lit;
      iexu_pkg::TagOr:  alu_res = a | b | q_data.lit;
      iexu_pkg::TagXor: alu_res = a ^ b ^ q_data.lit;
      iexu_pkg::TagCne: alu_res = 32'(a != bl);
      iexu_pkg::TagCeq: alu_res = 32'(a == bl);
      iexu_pkg::TagClt: alu_res = 32'(a < bl);
      iexu_pkg::TagCle: alu_res = 32'(a <= bl);
      iexu_pkg::TagFne: alu_res = 32'(un || ka != kb);
      iexu_pkg::TagFeq: alu_res = 32'(!un && ka == kb);
      iexu_pkg::TagFlt: alu_res = 32'(!un && ka < kb);
      iexu_pkg::TagFle: alu_res = 32'(!un && ka <= kb);
      default:          alu_res = '0;
    endcase
  end

  // Write-back and next program counter.
  always_comb begin
    we  = 1'b0;
    val = '0;
    nxt = pc + 32'd4;
    if (q_data.halt) begin
      nxt = pc;
    end else if (q_data.status == iexu_pkg::StExec) begin
      unique case (q_data.opcode)
        iexu_pkg::OpAlu:  begin we = 1'b1; val = alu_res; end
        iexu_pkg::OpLdi:  begin we = 1'b1; val = q_data.disp; end
        iexu_pkg::OpLdih: begin we = 1'b1; val = {q_data.disp[15:0], a[15:0]}; end
        iexu_pkg::OpJal:  begin we = 1'b1; val = pc + 32'd4; nxt = br_tgt; end
        iexu_pkg::OpJr:   nxt = x;
        iexu_pkg::OpBne:  if (x != a) nxt = br_tgt;
        iexu_pkg::OpBeq:  if (x == a) nxt = br_tgt;
        default: ;
      endcase
    end
  end

  assign q_pop = q_valid && (!out_valid || !out_stall);
  assign load  = q_pop;

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < iexu_pkg::RegCount; i++) begin
        regs[i] <= '0;
      end
      regs[30] <= iexu_pkg::StackInit;
      regs[31] <= iexu_pkg::StackInit;
      pc <= iexu_pkg::PcInit;
    end else if (load) begin
      if (we) regs[q_data.rx] <= val;
      pc <= nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status       <= q_data.status;
      write_enable <= we;
      write_index  <= we ? q_data.rx : 5'd0;
      write_value  <= we ? val : 32'd0;
      next_pc      <= nxt;
    end
  end

  a_pc_hold: assert property (@(posedge clk) disable iff (rst) !load |=> $stable(pc))
    else $error("pc changed without a request");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(next_pc))
    else $error("stalled result changed");
  a_halt_pc: assert property (@(posedge clk) disable iff (rst)
    (load && q_data.halt) |=> pc == $past(pc))
    else $error("halt moved pc");

endmodule

@@ design/integer_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute unit
// Executes 32-bit integer, compare, immediate and branch instructions.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// request   in         valid / stall      instruction
// result    out        out_valid / out_stall  status, write_enable,
//                                          write_index, write_value, next_pc
//
// One instruction per cycle sustained while out_stall is low; the result passes
// through a two-entry queue and the output register.
// The register file read and ALU are combinational; write-back happens when a request is taken.
// Reset is synchronous; it loads the register file and pc.
// Stalls on the result side fill the queue, then raise stall.
// ----------------------------------------------------------------------------
module integer_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        stall,
  input  logic [31:0] instruction,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        write_enable,
  output logic [4:0]  write_index,
  output logic [31:0] write_value,
  output logic [31:0] next_pc
);

  logic           q_valid;
  logic           q_pop;
  iexu_pkg::dec_t q_data;

  iexu_front u_front (
    .clk, .rst, .valid, .stall, .instruction,
    .q_valid, .q_pop, .q_data
  );

  iexu_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_data,
    .out_valid, .out_stall, .status, .write_enable,
    .write_index, .write_value, .next_pc
  );

endmodule

@@ tb/integer_execute_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer execute unit testbench
// Sends instruction requests through the valid/stall channel and checks every
// result against an in-bench predictor of the register file and pc. Covers
// directed corner cases, random programs with some noise and back-pressure.
// ----------------------------------------------------------------------------
module integer_execute_unit_tb;

  typedef struct packed {
    logic [1:0]  status;
    logic        we;
    logic [4:0]  idx;
    logic [31:0] value;
    logic [31:0] pc;
  } exec_result_t;

  // Codes that the design leaves unused, for corner cases.
  localparam logic [3:0] OpSpareLow  = 4'd4;
  localparam logic [3:0] OpSpareHigh = 4'd14;
  localparam logic [4:0] TagBadLow   = 5'd8;
  localparam logic [4:0] TagBadHigh  = 5'd23;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        stall;
  logic [31:0] instruction = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        write_enable;
  logic [4:0]  write_index;
  logic [31:0] write_value;
  logic [31:0] next_pc;

  logic [31:0]  regs [iexu_pkg::RegCount];
  logic [31:0]  pc;
  exec_result_t pending_results [$];
  int           mismatches = 0;
  bit           idle_enable = 1'b0;
  int           hold_cycles = 0;

  integer_execute_unit uut (.*);

  always #1 clk = ~clk;

  // Predictor state at reset.
  task automatic reset_model();
    foreach (regs[i]) regs[i] = '0;
    regs[30] = iexu_pkg::StackInit;
    regs[31] = iexu_pkg::StackInit;
    pc = iexu_pkg::PcInit;
  endtask

  function automatic logic is_nan(logic [31:0] x);
    return (x[30:23] == 8'hff) && (x[22:0] != '0);
  endfunction

  // Order key so unsigned compares follow float order; both zeros map alike.
  function automatic logic [31:0] float_key(logic [31:0] x);
    if (x[30:0] == '0) x = '0;
    return x[31] ? ~x : (x | 32'h8000_0000);
  endfunction

  // Execute one instruction against the predictor state.
  function automatic exec_result_t execute(logic [31:0] inst);
    exec_result_t r;
    logic [3:0]  op;
    logic [4:0]  rx, ra, rb, tag;
    logic [31:0] a, b, lit, disp, bl, ka, kb, target;
    logic        un;
    op = inst[31:28]; rx = inst[27:23]; ra = inst[22:18]; rb = inst[17:13];
    tag = inst[4:0];
    lit = {{24{inst[12]}}, inst[12:5]};
    disp = {{16{inst[15]}}, inst[15:0]};
    a = regs[ra]; b = regs[rb]; bl = b + lit;
    target = pc + 32'd4 + (disp << 2);
    r = '0;
    r.pc = pc + 32'd4;
    if (inst == iexu_pkg::HaltWord) begin
      r.status = iexu_pkg::StHalt;
      r.pc = pc;
    end else begin
      case (op)
        iexu_pkg::OpAlu: begin
          r.we = 1'b1;
          ka = float_key(a); kb = float_key(b);
          un = is_nan(a) || is_nan(b);
          case (tag)
            iexu_pkg::TagAdd: r.value = a + b + lit;
            iexu_pkg::TagSub: r.value = a - b - lit;
            iexu_pkg::TagShl: r.value = a << bl[4:0];
            iexu_pkg::TagShr: r.value = a >> bl[4:0];
            iexu_pkg::TagSar: r.value = $signed(a) >>> bl[4:0];
            iexu_pkg::TagAnd: r.value = a & b & lit;
            iexu_pkg::TagOr:  r.value = a | b | lit;
            iexu_pkg::TagXor: r.value = a ^ b ^ lit;
            iexu_pkg::TagCne: r.value = 32'(a != bl);
            iexu_pkg::TagCeq: r.value = 32'(a == bl);
            iexu_pkg::TagClt: r.value = 32'(a < bl);
            iexu_pkg::TagCle: r.value = 32'(a <= bl);
            iexu_pkg::TagFne: r.value = 32'(un || ka != kb);
            iexu_pkg::TagFeq: r.value = 32'(!un && ka == kb);
            iexu_pkg::TagFlt: r.value = 32'(!un && ka < kb);
            iexu_pkg::TagFle: r.value = 32'(!un && ka <= kb);
            default: begin
              r.we = 1'b0;
              r.status = iexu_pkg::StBadTag;
            end
          endcase
        end
        iexu_pkg::OpFpu, iexu_pkg::OpStore, iexu_pkg::OpLoad:
          r.status = iexu_pkg::StUnsup;
        iexu_pkg::OpLdi: begin
          r.we = 1'b1;
          r.value = disp;
        end
        iexu_pkg::OpLdih: begin
          r.we = 1'b1;
          r.value = {disp[15:0], a[15:0]};
        end
        iexu_pkg::OpJal: begin
          r.we = 1'b1;
          r.value = pc + 32'd4;
          r.pc = target;
        end
        iexu_pkg::OpJr:  r.pc = regs[rx];
        iexu_pkg::OpBne: if (regs[rx] != a) r.pc = target;
        iexu_pkg::OpBeq: if (regs[rx] == a) r.pc = target;
        default: ;
      endcase
    end
    if (r.we) begin
      regs[rx] = r.value;
      r.idx = rx;
    end
    pc = r.pc;
    return r;
  endfunction

  // Send one request, predicting its result when it is accepted.
  task automatic send(logic [31:0] inst);
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    valid <= 1'b1;
    instruction <= inst;
    @(posedge clk);
    while (stall) @(posedge clk);
    pending_results.push_back(execute(inst));
    @(negedge clk);
  endtask

  task automatic pause_sender();
    valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Receiver stall: long hold when requested, otherwise random bursts.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
        out_stall <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    exec_result_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = {status, write_enable, write_index, write_value, next_pc};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected st=%0d we=%0d idx=%0d val=%h pc=%h",
                     want.status, want.we, want.idx, want.value, want.pc);
            $display("          got      st=%0d we=%0d idx=%0d val=%h pc=%h",
                     got.status, got.we, got.idx, got.value, got.pc);
          end
        end
      end
    end
  end

  function automatic logic [31:0] alu_word(logic [4:0] rx, logic [4:0] ra,
                                           logic [4:0] rb, logic [7:0] lit,
                                           logic [4:0] tag);
    return {iexu_pkg::OpAlu, rx, ra, rb, lit, tag};
  endfunction

  function automatic logic [31:0] disp_word(logic [3:0] op, logic [4:0] rx,
                                            logic [4:0] ra, logic [15:0] disp);
    return {op, rx, ra, 2'b00, disp};
  endfunction

  // Interesting float and integer values for register loads.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7fc0_0000;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hff80_0000;
      4: return 32'h3f80_0000;
      5: return 32'hbf80_0000;
      default: return $urandom;
    endcase
  endfunction

  // Load a full 32-bit value into a register with ldi then ldih.
  task automatic load_reg(logic [4:0] r, logic [31:0] v);
    send(disp_word(iexu_pkg::OpLdi, r, 5'd0, v[15:0]));
    send(disp_word(iexu_pkg::OpLdih, r, r, v[31:16]));
  endtask

  task automatic test_directed();
    send(iexu_pkg::HaltWord);
    load_reg(5'd1, 32'h7fc0_0000);
    load_reg(5'd2, 32'h8000_0000);
    send(alu_word(5'd3, 5'd2, 5'd0, 8'h00, iexu_pkg::TagFeq));
    send(alu_word(5'd4, 5'd1, 5'd1, 8'h00, iexu_pkg::TagFne));
    send(alu_word(5'd5, 5'd1, 5'd2, 8'h00, iexu_pkg::TagFle));
    send(alu_word(5'd6, 5'd2, 5'd30, 8'h80, iexu_pkg::TagSar));
    send(alu_word(5'd7, 5'd2, 5'd31, 8'h7f, iexu_pkg::TagSub));
    send(alu_word(5'd0, 5'd31, 5'd30, 8'hff, iexu_pkg::TagClt));
    send(alu_word(5'd8, 5'd0, 5'd0, 8'h00, TagBadLow));
    send(alu_word(5'd8, 5'd0, 5'd0, 8'h00, TagBadHigh));
    send(disp_word(iexu_pkg::OpFpu, 5'd0, 5'd0, 16'h0));
    send(disp_word(iexu_pkg::OpStore, 5'd0, 5'd0, 16'h0));
    send(disp_word(iexu_pkg::OpLoad, 5'd0, 5'd0, 16'h0));
    send(disp_word(OpSpareLow, 5'd0, 5'd0, 16'h0));
    send(disp_word(OpSpareHigh, 5'd31, 5'd31, 16'hffff));
    send(disp_word(iexu_pkg::OpJal, 5'd9, 5'd0, 16'h8000));
    send(disp_word(iexu_pkg::OpBeq, 5'd30, 5'd31, 16'h7fff));
    send(disp_word(iexu_pkg::OpBne, 5'd30, 5'd31, 16'h0001));
    send(disp_word(iexu_pkg::OpJr, 5'd2, 5'd0, 16'h0));
    send(32'hffff_fffe);
  endtask

  // Random programs: mostly valid ALU/immediate/branch words, some noise.
  task automatic test_random(int count);
    logic [31:0] w;
    logic [4:0]  tag;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1: load_reg(5'($urandom), pick_value());
        2, 3, 4: begin
          tag = ($urandom_range(0, 3) == 0)
              ? 5'($urandom_range(iexu_pkg::TagCne, iexu_pkg::TagFle))
              : 5'($urandom_range(iexu_pkg::TagAdd, iexu_pkg::TagXor));
          send(alu_word(5'($urandom), 5'($urandom), 5'($urandom),
                        8'($urandom), tag));
        end
        5: send(disp_word(4'($urandom_range(iexu_pkg::OpJal, iexu_pkg::OpBeq)),
                          5'($urandom), 5'($urandom), 16'($urandom)));
        6: send(iexu_pkg::HaltWord);
        default: begin
          w = $urandom;
          send(w);
        end
      endcase
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 60;
    repeat (20) send($urandom);
    pause_sender();
  endtask

  initial begin
    reset_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    pause_sender();
    idle_enable = 1'b1;
    test_backpressure();
    test_random(580);
    idle_enable = 1'b0;
    test_random(130);
    valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #200000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ files.f @@
design/iexu_pkg.sv
design/iexu_front.sv
design/iexu_back.sv
design/integer_execute_unit.sv
tb/integer_execute_unit_tb.sv
